// ===== rtl/rjp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjp_pkg
// Shared types, constants and the control store of the RTP/JPEG packetiser.
// ----------------------------------------------------------------------------
package rjp_pkg;

    // quantisation block and word packing
    localparam int QUANT_BYTES   = 128;
    localparam int QADDR_W       = $clog2(QUANT_BYTES);
    localparam int WORD_BYTES    = 8;
    localparam int CNT_W         = 4;

    // header lengths on the JPEG side of a packet
    localparam int JPEG_HDR_BYTES  = 8;
    localparam int QUANT_HDR_BYTES = 4;
    localparam int FIRST_HDR_BYTES = JPEG_HDR_BYTES + QUANT_HDR_BYTES + QUANT_BYTES;

    // header byte constants
    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] PT_JPEG          = 8'd26;
    localparam logic [7:0] JPEG_Q           = 8'd255;
    localparam logic [7:0] JPEG_TYPE        = 8'h01;
    localparam logic [7:0] RESTART_FLAG     = 8'h40;
    localparam logic [7:0] QLEN_HI          = 8'((QUANT_BYTES >> 8) & 8'hFF);
    localparam logic [7:0] QLEN_LO          = 8'(QUANT_BYTES & 8'hFF);

    // configuration register indexes
    localparam logic [1:0] CFG_CAPACITY = 2'd0;
    localparam logic [1:0] CFG_WIDTH    = 2'd1;
    localparam logic [1:0] CFG_HEIGHT   = 2'd2;
    localparam logic [1:0] CFG_RESTART  = 2'd3;

    // configuration reset values
    localparam logic [15:0] CAPACITY_RST = 16'd1400;
    localparam logic [10:0] WIDTH_RST    = 11'd640;
    localparam logic [10:0] HEIGHT_RST   = 11'd480;

    // request kinds
    localparam logic REQ_QUANT = 1'b0;
    localparam logic REQ_DATA  = 1'b1;

    // byte source selected by a control word
    typedef enum logic [3:0] {
        SRC_NONE,
        SRC_CONST,
        SRC_MARK_PT,
        SRC_SEQ_HI,
        SRC_SEQ_LO,
        SRC_OFF_HI,
        SRC_OFF_MID,
        SRC_OFF_LO,
        SRC_TYPE,
        SRC_WIDTH,
        SRC_HEIGHT,
        SRC_QUANT,
        SRC_DATA
    } src_t;

    // sequencing of a control word
    typedef enum logic [1:0] {
        BR_NEXT,
        BR_NOTFIRST,
        BR_QLOOP,
        BR_DONE
    } br_t;

    typedef logic [4:0] step_t;

    // step addresses
    localparam step_t STEP_IDLE  = 5'd0;
    localparam step_t STEP_SETUP = 5'd1;
    localparam step_t STEP_HDR   = 5'd2;
    localparam step_t STEP_QPRE  = 5'd22;
    localparam step_t STEP_QLOOP = 5'd26;
    localparam step_t STEP_DATA  = 5'd27;

    typedef struct packed {
        src_t       src;
        logic [7:0] konst;
        br_t        br;
        step_t      target;
        logic       tail;     // may carry the final word of a header burst
    } uword_t;

    // control store: one word per step
    function automatic uword_t ucode_rom(step_t pc);
        uword_t w;
        w = '{src: SRC_NONE, konst: 8'h00, br: BR_DONE, target: STEP_IDLE, tail: 1'b0};
        unique case (pc) inside
            STEP_SETUP:      w = '{SRC_NONE,    8'h00,            BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_HDR + 5'd0: w = '{SRC_CONST,   RTP_VERSION_BYTE, BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_HDR + 5'd1: w = '{SRC_MARK_PT, 8'h00,            BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_HDR + 5'd2: w = '{SRC_SEQ_HI,  8'h00,            BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_HDR + 5'd3: w = '{SRC_SEQ_LO,  8'h00,            BR_NEXT,     STEP_IDLE, 1'b0};
            [STEP_HDR + 5'd4 : STEP_HDR + 5'd12]:
                             w = '{SRC_CONST,   8'h00,            BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_HDR + 5'd13: w = '{SRC_OFF_HI, 8'h00,            BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_HDR + 5'd14: w = '{SRC_OFF_MID, 8'h00,           BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_HDR + 5'd15: w = '{SRC_OFF_LO, 8'h00,            BR_NEXT,     STEP_IDLE, 1'b1};
            STEP_HDR + 5'd16: w = '{SRC_TYPE,   8'h00,            BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_HDR + 5'd17: w = '{SRC_CONST,  JPEG_Q,           BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_HDR + 5'd18: w = '{SRC_WIDTH,  8'h00,            BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_HDR + 5'd19: w = '{SRC_HEIGHT, 8'h00,            BR_NOTFIRST, STEP_DATA, 1'b0};
            STEP_QPRE + 5'd0: w = '{SRC_CONST,  8'h00,            BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_QPRE + 5'd1: w = '{SRC_CONST,  8'h00,            BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_QPRE + 5'd2: w = '{SRC_CONST,  QLEN_HI,          BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_QPRE + 5'd3: w = '{SRC_CONST,  QLEN_LO,          BR_NEXT,     STEP_IDLE, 1'b0};
            STEP_QLOOP:      w = '{SRC_QUANT,   8'h00,            BR_QLOOP,    STEP_IDLE, 1'b1};
            STEP_DATA:       w = '{SRC_DATA,    8'h00,            BR_DONE,     STEP_IDLE, 1'b0};
            default:         w = '{SRC_NONE,    8'h00,            BR_DONE,     STEP_IDLE, 1'b0};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/rtp_jpeg_packetizer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_jpeg_packetizer_core
// Cuts a JPEG frame into RTP/JPEG packets and packs them into 64-bit words.
// ----------------------------------------------------------------------------
// Input stream: quant-table loads (tuser 0) and frame bytes (tuser 1), one
// request a beat. Quant loads go into a 128-byte table and produce nothing.
// Output stream: 64-bit words, first packet byte in bits 63:56, with the
// byte count and a last-of-request flag in tuser and tlast on a packet's
// final word. Configuration is a plain write port; the user must write it
// only while idle, the block does not enforce it. Frame bytes in an open
// packet, quant loads and out-of-frame bytes stream at one per clock unless
// the output stalls. A byte that opens a packet starts the microcoded header
// sequencer: one header byte per cycle unless the output stalls; on a frame's
// first packet it also walks the quant table. The input is not ready while
// the sequencer runs or while a finished word waits and the receiver stalls;
// a stalled output freezes the sequencer on the word that would overwrite it.
// Output words appear in the cycle after the byte that completes them. Reset
// clears the sequence number, offsets, packing state and the output valid and
// loads the default configuration; the quant table is not cleared.
// ----------------------------------------------------------------------------
module rtp_jpeg_packetizer_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    // table_index [6:0], byte_value [14:7], frame_length [38:15], zero [39]
    input  logic [39:0] s_tdata,
    // req_type [0]
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // out_word [63:0]
    output logic [63:0] m_tdata,
    // valid_bytes [3:0], last_of_run [4]
    output logic [4:0]  m_tuser,
    output logic        m_tlast
);

    localparam int ACC_W = 8 * rjp_pkg::WORD_BYTES;

    // input fields
    logic [rjp_pkg::QADDR_W-1:0] in_index;
    logic [7:0]                  in_byte;
    logic [23:0]                 in_flen;

    assign in_index = s_tdata[6:0];
    assign in_byte  = s_tdata[14:7];
    assign in_flen  = s_tdata[38:15];

    // configuration
    logic [15:0] cap_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [15:0] restart_reg;

    // packet state
    logic [15:0] seq_reg,  seq_next;
    logic [23:0] fo_reg,   fo_next;
    logic [15:0] fill_reg, fill_next;
    logic        first_reg, first_next;

    // header run state
    logic [23:0] diff_reg, diff_next;
    logic        mark_reg, mark_next;
    logic        end_reg,  end_next;
    logic        endf_reg, endf_next;
    logic [7:0]  byte_reg, byte_next;

    // sequencer
    rjp_pkg::step_t pc_reg, pc_next;
    rjp_pkg::uword_t uw;

    // quant table
    logic [7:0]                  quant_mem [rjp_pkg::QUANT_BYTES];
    logic [7:0]                  q_rdata_reg;
    logic [rjp_pkg::QADDR_W-1:0] q_addr_reg, q_addr_next;
    logic                        q_last;

    // word packing
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic [rjp_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    // output register
    logic                      m_valid_reg, m_valid_next;
    logic [ACC_W-1:0]          m_word_reg;
    logic [rjp_pkg::CNT_W-1:0] m_bytes_reg;
    logic                      m_eop_reg;
    logic                      m_lor_reg;

    // handshake
    logic out_free;
    logic s_accept;

    // push path
    logic                      push_req;
    logic                      push_en;
    logic [7:0]                push_byte;
    logic                      push_last;
    logic                      push_lor;
    logic                      emit;
    logic                      flush_emit;
    logic                      go;
    logic [5:0]                shift_amt;
    logic [ACC_W-1:0]          acc_ins;
    logic [rjp_pkg::CNT_W-1:0] cnt_inc;

    // fast path decode
    logic        in_range;
    logic        fast_endf;
    logic        fast_endr;
    logic        fast_end;
    logic [7:0]  hdr_len;
    logic        cap_small;
    logic [24:0] mark_sum;
    logic [16:0] fill_sum;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (pc_reg == rjp_pkg::STEP_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    assign uw     = rjp_pkg::ucode_rom(pc_reg);
    assign q_last = (q_addr_reg == rjp_pkg::QADDR_W'(rjp_pkg::QUANT_BYTES - 1));

    // header length and capacity test for the open packet
    assign hdr_len   = first_reg ? 8'(rjp_pkg::FIRST_HDR_BYTES)
                                 : 8'(rjp_pkg::JPEG_HDR_BYTES);
    assign cap_small = (cap_reg <= {8'd0, hdr_len});

    // frame byte inside an open packet
    assign in_range  = (fo_reg < in_flen);
    assign fast_endf = ((fo_reg + 24'd1) == in_flen);
    assign fill_sum  = {1'b0, fill_reg} + {9'd0, hdr_len} + 17'd1;
    assign fast_endr = cap_small || (fill_sum >= {1'b0, cap_reg});
    assign fast_end  = fast_endf || fast_endr;

    // marker test at packet open
    assign mark_sum = {1'b0, diff_reg} + {17'd0, hdr_len};

    // byte source and push request
    always_comb
    begin
        push_req  = 1'b0;
        push_byte = 8'h00;
        push_last = 1'b0;
        push_lor  = 1'b0;
        if (pc_reg == rjp_pkg::STEP_IDLE)
        begin
            push_req  = s_accept && (s_tuser == rjp_pkg::REQ_DATA) && in_range
                        && (fill_reg != 16'd0);
            push_byte = in_byte;
            push_last = fast_end;
            push_lor  = 1'b1;
        end
        else
        begin
            push_req = (uw.src != rjp_pkg::SRC_NONE);
            case (uw.src)
                rjp_pkg::SRC_CONST:   push_byte = uw.konst;
                rjp_pkg::SRC_MARK_PT: push_byte = {mark_reg, rjp_pkg::PT_JPEG[6:0]};
                rjp_pkg::SRC_SEQ_HI:  push_byte = seq_reg[15:8];
                rjp_pkg::SRC_SEQ_LO:  push_byte = seq_reg[7:0];
                rjp_pkg::SRC_OFF_HI:  push_byte = fo_reg[23:16];
                rjp_pkg::SRC_OFF_MID: push_byte = fo_reg[15:8];
                rjp_pkg::SRC_OFF_LO:  push_byte = fo_reg[7:0];
                rjp_pkg::SRC_TYPE:    push_byte = rjp_pkg::JPEG_TYPE
                                        | ((restart_reg != 16'd0) ? rjp_pkg::RESTART_FLAG
                                                                  : 8'h00);
                rjp_pkg::SRC_WIDTH:   push_byte = width_reg[10:3];
                rjp_pkg::SRC_HEIGHT:  push_byte = height_reg[10:3];
                rjp_pkg::SRC_QUANT:   push_byte = q_rdata_reg;
                rjp_pkg::SRC_DATA:    push_byte = byte_reg;
                default:              push_byte = 8'h00;
            endcase
            if (uw.src == rjp_pkg::SRC_DATA)
            begin
                push_last = end_reg;
                push_lor  = 1'b1;
            end
            else
            begin
                push_last = 1'b0;
                // the header's final word is last of the request when the data
                // byte that follows leaves its word open
                push_lor  = uw.tail && !end_reg
                            && ((uw.src == rjp_pkg::SRC_QUANT) ? q_last : !first_reg);
            end
        end
    end

    // packing datapath
    assign shift_amt = {3'd7 - cnt_reg[2:0], 3'b000};
    assign acc_ins   = acc_reg | ({{(ACC_W-8){1'b0}}, push_byte} << shift_amt);
    assign cnt_inc   = cnt_reg + rjp_pkg::CNT_W'(1);

    // stall on a word that has nowhere to go
    assign go      = !(push_req && (push_last
                       || (cnt_reg == rjp_pkg::CNT_W'(rjp_pkg::WORD_BYTES - 1))))
                     || out_free;
    assign push_en = push_req && go;
    assign emit    = push_en && (push_last
                     || (cnt_reg == rjp_pkg::CNT_W'(rjp_pkg::WORD_BYTES - 1)));

    // out-of-frame byte closes an open packet
    assign flush_emit = s_accept && (s_tuser == rjp_pkg::REQ_DATA) && !in_range
                        && (fill_reg != 16'd0);

    // sequencer and packet state
    always_comb
    begin
        pc_next     = pc_reg;
        seq_next    = seq_reg;
        fo_next     = fo_reg;
        fill_next   = fill_reg;
        first_next  = first_reg;
        diff_next   = diff_reg;
        mark_next   = mark_reg;
        end_next    = end_reg;
        endf_next   = endf_reg;
        byte_next   = byte_reg;
        q_addr_next = q_addr_reg;
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;

        if (pc_reg == rjp_pkg::STEP_IDLE)
        begin
            if (s_accept && (s_tuser == rjp_pkg::REQ_DATA))
            begin
                if (!in_range)
                begin
                    fo_next   = 24'd0;
                    fill_next = 16'd0;
                end
                else if (fill_reg != 16'd0)
                begin
                    fo_next   = fast_endf ? 24'd0 : fo_reg + 24'd1;
                    fill_next = fast_end ? 16'd0 : fill_reg + 16'd1;
                end
                else
                begin
                    byte_next = in_byte;
                    diff_next = in_flen;
                    pc_next   = rjp_pkg::STEP_SETUP;
                end
            end
        end
        else
        begin
            // packet open: distance to frame end and first-packet flag
            if (pc_reg == rjp_pkg::STEP_SETUP)
            begin
                diff_next  = diff_reg - fo_reg;
                first_next = (fo_reg == 24'd0);
            end
            // marker and end flags, ready before the marker byte
            if (pc_reg == rjp_pkg::STEP_HDR)
            begin
                endf_next = (diff_reg == 24'd1);
                end_next  = (diff_reg == 24'd1) || fast_endr;
                mark_next = cap_small ? (diff_reg == 24'd1)
                                      : (mark_sum <= {9'd0, cap_reg});
            end

            // quant read address runs ahead of the registered read data
            if (pc_reg != rjp_pkg::STEP_QLOOP)
                q_addr_next = '0;
            else if (go)
                q_addr_next = q_addr_reg + rjp_pkg::QADDR_W'(1);

            if (go)
            begin
                unique case (uw.br)
                    rjp_pkg::BR_NEXT:     pc_next = pc_reg + 5'd1;
                    rjp_pkg::BR_NOTFIRST: pc_next = first_reg ? pc_reg + 5'd1 : uw.target;
                    rjp_pkg::BR_QLOOP:    pc_next = q_last ? pc_reg + 5'd1 : pc_reg;
                    rjp_pkg::BR_DONE:     pc_next = rjp_pkg::STEP_IDLE;
                    default:              pc_next = rjp_pkg::STEP_IDLE;
                endcase
                if (uw.src == rjp_pkg::SRC_DATA)
                begin
                    seq_next  = seq_reg + 16'd1;
                    fo_next   = endf_reg ? 24'd0 : fo_reg + 24'd1;
                    fill_next = end_reg ? 16'd0 : 16'd1;
                end
            end
        end

        // word accumulator
        if (emit || flush_emit)
        begin
            acc_next = '0;
            cnt_next = '0;
        end
        else if (push_en)
        begin
            acc_next = acc_ins;
            cnt_next = cnt_inc;
        end
    end

    // output valid
    always_comb
    begin
        if (emit || flush_emit)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= rjp_pkg::STEP_IDLE;
            seq_reg     <= 16'd0;
            fo_reg      <= 24'd0;
            fill_reg    <= 16'd0;
            first_reg   <= 1'b0;
            mark_reg    <= 1'b0;
            end_reg     <= 1'b0;
            endf_reg    <= 1'b0;
            q_addr_reg  <= '0;
            acc_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg      <= pc_next;
            seq_reg     <= seq_next;
            fo_reg      <= fo_next;
            fill_reg    <= fill_next;
            first_reg   <= first_next;
            mark_reg    <= mark_next;
            end_reg     <= end_next;
            endf_reg    <= endf_next;
            q_addr_reg  <= q_addr_next;
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= rjp_pkg::CAPACITY_RST;
            width_reg   <= rjp_pkg::WIDTH_RST;
            height_reg  <= rjp_pkg::HEIGHT_RST;
            restart_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rjp_pkg::CFG_CAPACITY: cap_reg     <= cfg_data;
                rjp_pkg::CFG_WIDTH:    width_reg   <= cfg_data[10:0];
                rjp_pkg::CFG_HEIGHT:   height_reg  <= cfg_data[10:0];
                rjp_pkg::CFG_RESTART:  restart_reg <= cfg_data;
                default:               restart_reg <= restart_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        byte_reg <= byte_next;
        if (emit)
        begin
            m_word_reg  <= acc_ins;
            m_bytes_reg <= cnt_inc;
            m_eop_reg   <= push_last;
            m_lor_reg   <= push_lor;
        end
        else if (flush_emit)
        begin
            m_word_reg  <= acc_reg;
            m_bytes_reg <= cnt_reg;
            m_eop_reg   <= 1'b1;
            m_lor_reg   <= 1'b1;
        end
    end

    // quant table, registered read
    always_ff @(posedge clk)
    begin
        if (s_accept && (s_tuser == rjp_pkg::REQ_QUANT))
            quant_mem[in_index] <= in_byte;
        q_rdata_reg <= quant_mem[q_addr_next];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_word_reg;
    assign m_tuser  = {m_lor_reg, m_bytes_reg};
    assign m_tlast  = m_eop_reg;

endmodule

// ===== test/rjp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rjp_packet_checker
// Watches the ports of the RTP/JPEG packetiser and checks every output word.
// ----------------------------------------------------------------------------
// Mirrors configuration writes and accepted requests into a local model of
// the packetiser (quant table, sequence number, frame offset, packet fill and
// word packing), queues the words each request should produce, and compares
// every accepted output word field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module rjp_packet_checker
    import rjp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [4:0]  m_tuser,
    input  logic        m_tlast,

    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        eop;
        logic        last;
    } pkt_word_t;

    // mirrored configuration
    logic [15:0] capacity;
    logic [10:0] width_px;
    logic [10:0] height_px;
    logic [15:0] restart_len;

    // mirrored packetiser state
    logic [7:0]  qtable [QUANT_BYTES];
    logic [15:0] seq_num;
    logic [23:0] frame_pos;
    logic [15:0] fill;
    logic [63:0] acc;
    logic [3:0]  acc_n;

    pkt_word_t   expected_words [$];
    int          fail_cnt;

    // queue one output word
    function automatic void queue_word(logic [63:0] w, logic [3:0] n, logic eop);
        pkt_word_t r;
        r.bytes = w;
        r.count = n;
        r.eop   = eop;
        r.last  = 1'b0;
        expected_words.push_back(r);
    endfunction

    // pack one byte, first byte at the top of the word
    function automatic void pack_byte(logic [7:0] b, logic closes);
        acc = acc | (64'(b) << (56 - 8 * acc_n));
        acc_n++;
        if (closes || acc_n >= WORD_BYTES)
        begin
            queue_word(acc, acc_n, closes);
            acc   = '0;
            acc_n = '0;
        end
    endfunction

    // payload room left after the jpeg-side headers
    function automatic logic [15:0] payload_room(logic first);
        int unsigned hdr;
        hdr = JPEG_HDR_BYTES + (first ? QUANT_HDR_BYTES + QUANT_BYTES : 0);
        return (capacity > hdr) ? 16'(capacity - hdr) : 16'd1;
    endfunction

    // rtp header, jpeg header and, on the first packet, the quant block
    function automatic void pack_headers(logic first, logic mark, logic [23:0] off);
        logic [159:0] hdr;
        logic [7:0]   type_byte;
        int           i;
        type_byte = JPEG_TYPE | ((restart_len != 0) ? RESTART_FLAG : 8'h00);
        hdr = {RTP_VERSION_BYTE, mark, PT_JPEG[6:0], seq_num, 64'd0, 8'd0, off,
               type_byte, JPEG_Q, width_px[10:3], height_px[10:3]};
        for (i = 0; i < 20; i++)
            pack_byte(hdr[159 - 8 * i -: 8], 1'b0);
        if (first)
        begin
            pack_byte(8'h00, 1'b0);
            pack_byte(8'h00, 1'b0);
            pack_byte(QLEN_HI, 1'b0);
            pack_byte(QLEN_LO, 1'b0);
            for (i = 0; i < QUANT_BYTES; i++)
                pack_byte(qtable[i], 1'b0);
        end
    endfunction

    // words caused by one accepted request
    function automatic void predict_packet_words(logic kind, logic [6:0] idx,
                                                 logic [7:0] val, logic [23:0] flen);
        int          prior_count;
        logic [23:0] start;
        logic        first;
        logic [15:0] room;
        logic        done;
        pkt_word_t   r;
        prior_count = expected_words.size();
        if (kind == REQ_QUANT)
        begin
            if (idx < QUANT_BYTES)
                qtable[idx] = val;
            return;
        end
        if (frame_pos >= flen)
        begin
            // beyond the frame: byte dropped, open packet closed
            if (fill != 0)
            begin
                queue_word(acc, acc_n, 1'b1);
                acc   = '0;
                acc_n = '0;
            end
            frame_pos = '0;
            fill      = '0;
        end
        else
        begin
            start = frame_pos - 24'(fill);
            first = (start == 0);
            room  = payload_room(first);
            if (fill == 0)
            begin
                pack_headers(first, (flen - frame_pos) <= 24'(room), frame_pos);
                seq_num++;
            end
            frame_pos++;
            fill++;
            done = (frame_pos >= flen) || (fill >= room);
            pack_byte(val, done);
            if (done)
            begin
                fill = '0;
                if (frame_pos >= flen)
                    frame_pos = '0;
            end
        end
        // flag the final word of this request
        if (expected_words.size() > prior_count)
        begin
            r = expected_words.pop_back();
            r.last = 1'b1;
            expected_words.push_back(r);
        end
    endfunction

    // mirror config, predict on requests, compare on words
    always @(posedge clk or negedge rst_n)
    begin : watch
        pkt_word_t want;
        if (!rst_n)
        begin
            capacity    = CAPACITY_RST;
            width_px    = WIDTH_RST;
            height_px   = HEIGHT_RST;
            restart_len = '0;
            seq_num     = '0;
            frame_pos   = '0;
            fill        = '0;
            acc         = '0;
            acc_n       = '0;
            fail_cnt    = 0;
            expected_words.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CAPACITY: capacity    = cfg_data;
                    CFG_WIDTH:    width_px    = cfg_data[10:0];
                    CFG_HEIGHT:   height_px   = cfg_data[10:0];
                    CFG_RESTART:  restart_len = cfg_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                predict_packet_words(s_tuser, s_tdata[6:0], s_tdata[14:7],
                                     s_tdata[38:15]);

            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    if (fail_cnt < 10)
                        $display("unexpected word %h bytes %0d eop %b last %b",
                                 m_tdata, m_tuser[3:0], m_tlast, m_tuser[4]);
                    fail_cnt++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (m_tdata !== want.bytes || m_tuser[3:0] !== want.count ||
                        m_tlast !== want.eop || m_tuser[4] !== want.last)
                    begin
                        if (fail_cnt < 10)
                            $display({"mismatch: expected %h bytes %0d eop %b last %b,",
                                      " got %h bytes %0d eop %b last %b"},
                                     want.bytes, want.count, want.eop, want.last,
                                     m_tdata, m_tuser[3:0], m_tlast, m_tuser[4]);
                        fail_cnt++;
                    end
                end
            end

            mismatches  <= fail_cnt;
            outstanding <= expected_words.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the RTP/JPEG packetiser.
// ----------------------------------------------------------------------------
// Loads the quant table, runs a short directed set (one-byte frames, zero
// and shrunk frame lengths, one-byte payloads, empty closing words, packet
// splits) and then random frames under changing configurations, with random
// idle bursts on both sides and one long output hold-off. The checker module
// predicts and compares; this module only drives stimulus and reports.
// ----------------------------------------------------------------------------
module tb_top;
    import rjp_pkg::*;

    localparam int RANDOM_ITEMS = 250;
    localparam int CALM_ITEMS   = 80;
    localparam int PHASE_ITEMS  = 50;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 600;
    localparam int SETTLE       = 200;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [4:0]  m_tuser;
    logic        m_tlast;

    int          mismatches;
    int          outstanding;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    logic        long_hold     = 1'b0;
    int          quiet_cycles  = 0;

    rtp_jpeg_packetizer_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    rjp_packet_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (rst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
        else
            quiet_cycles <= 0;
    end

    // output side: random stalls and the long hold-off
    initial
    begin : sink
        int gap;
        m_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct)
            begin
                m_tready <= 1'b0;
                gap = $urandom_range(1, 15);
                repeat (gap) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // offer one request and wait for it to be taken
    task automatic offer_request(input logic kind, input logic [6:0] idx,
                                 input logic [7:0] val, input logic [23:0] flen);
        int gap;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, flen, val, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // frame bytes with one length, random contents
    task automatic send_frame_bytes(input int n, input logic [23:0] flen);
        int j;
        for (j = 0; j < n; j++)
            offer_request(REQ_DATA, 7'($urandom), 8'($urandom), flen);
    endtask

    // wait until every expected word is out, then let the sequencer finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic program_cfg(input logic [15:0] cap, input logic [10:0] wid,
                               input logic [10:0] hgt, input logic [15:0] rint);
        write_reg(CFG_CAPACITY, cap);
        write_reg(CFG_WIDTH, {5'd0, wid});
        write_reg(CFG_HEIGHT, {5'd0, hgt});
        write_reg(CFG_RESTART, rint);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // one random sequence: quant loads, a cut-short frame or a whole frame
    task automatic send_sequence(output int sent);
        int          pick;
        int          n;
        int          j;
        logic [23:0] flen;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            n = $urandom_range(1, 4);
            for (j = 0; j < n; j++)
                offer_request(REQ_QUANT, 7'($urandom), 8'($urandom), 24'($urandom));
            sent = n;
        end
        else if (pick == 1)
        begin
            // huge length, then a short one drops the byte and closes the packet
            flen = 24'($urandom) | 24'h800000;
            n = $urandom_range(1, 12);
            send_frame_bytes(n, flen);
            offer_request(REQ_DATA, 7'($urandom), 8'($urandom), 24'($urandom_range(0, n)));
            sent = n + 1;
        end
        else
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(41, 400) : $urandom_range(1, 40);
            send_frame_bytes(n, 24'(n));
            sent = n;
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        int          i;
        int          items;
        int          phase;
        int          phase_items;
        int          sent;
        logic [15:0] cap;
        logic [10:0] wid;
        logic [10:0] hgt;
        logic [15:0] rint;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_CAPACITY;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= REQ_QUANT;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full quant table, extremes in the first two entries
        for (i = 0; i < QUANT_BYTES; i++)
            offer_request(REQ_QUANT, 7'(i),
                          (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
                          24'($urandom));

        // reset configuration: one-byte frame, zero length with nothing open
        offer_request(REQ_DATA, 7'h00, 8'hFF, 24'd1);
        offer_request(REQ_DATA, 7'h7F, 8'h00, 24'd0);
        // largest length, then a shrunk length closes a partial word
        offer_request(REQ_DATA, 7'h55, 8'h00, 24'hFFFFFF);
        offer_request(REQ_DATA, 7'h2A, 8'hA5, 24'hFFFFFF);
        offer_request(REQ_DATA, 7'h7F, 8'hFF, 24'hFFFFFF);
        offer_request(REQ_DATA, 7'h00, 8'h5A, 24'd1);
        send_frame_bytes(2, 24'd2);

        // capacity below the headers: one byte per packet, extreme sizes
        settle();
        program_cfg(16'd9, 11'd2047, 11'd2047, 16'hFFFF);
        send_frame_bytes(3, 24'd3);
        settle();
        program_cfg(16'd0, 11'd0, 11'd0, 16'd0);
        send_frame_bytes(2, 24'd2);

        // largest capacity: packet closed on a word boundary leaves an empty word
        settle();
        program_cfg(16'hFFFF, 11'd7, 11'd8, 16'd1);
        send_frame_bytes(8, 24'h800000);
        offer_request(REQ_DATA, 7'h01, 8'h81, 24'd0);

        // first packet of one byte, then a marked second packet
        settle();
        program_cfg(16'd141, 11'd1023, 11'd1024, 16'h8000);
        send_frame_bytes(3, 24'd3);

        // random phases
        items = 0;
        phase = 0;
        while (items < RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(0, 5))
                0: cap = 16'd256;
                1: cap = 16'hFFFF;
                2: cap = 16'($urandom_range(256, 1400));
                3: cap = 16'($urandom_range(0, 160));
                4: cap = 16'($urandom_range(141, 300));
                default: cap = 16'($urandom);
            endcase
            wid  = ($urandom_range(0, 3) == 0) ? 11'h7FF : 11'($urandom);
            hgt  = ($urandom_range(0, 3) == 0) ? 11'h000 : 11'($urandom);
            rint = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
            program_cfg(cap, wid, hgt, rint);

            src_idle_pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            sink_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            if (phase == 0)
            begin
                // hold the output off while requests keep coming
                src_idle_pct = 0;
                long_hold = 1'b1;
            end

            phase_items = 0;
            while (phase_items < PHASE_ITEMS && items + phase_items < RANDOM_ITEMS)
            begin
                if (items + phase_items >= RANDOM_ITEMS - CALM_ITEMS)
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
                send_sequence(sent);
                phase_items += sent;
            end
            items += phase_items;
            phase++;
        end

        // drain and report
        settle();
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
